// ===== design/wsp_pkg.sv =====
// wheel speed from pulse periods: shared types, codes and constants
// used by wsp_speed_calc and wheel_speed_from_pulse_periods_unit
`default_nettype none

package wsp_pkg;

  // request and result payloads
  typedef struct packed {
    logic        operation;
    logic [31:0] capture_time;
  } wsp_in_t;

  typedef struct packed {
    logic        edge_accepted;
    logic [15:0] speed_value;
    logic [7:0]  pulses_counted;
    logic [31:0] partial_pulses;
    logic [31:0] pending_ticks;
  } wsp_out_t;

  // operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // configuration register indexes
  localparam int CFG_DATA_W = 8;
  typedef enum logic [0:0] {
    CFG_MILES_MODE   = 1'b0,
    CFG_RATIO_ADJUST = 1'b1
  } cfg_index_t;

  // top level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_DECIDE,
    S_CALC,
    S_DONE
  } wsp_state_t;

  // speed calculator sequencer
  typedef enum logic [1:0] {
    C_IDLE,
    C_MUL,
    C_DIV,
    C_DONE
  } calc_state_t;

  localparam logic [3:0]  IDLE_LIMIT    = 4'd10;
  localparam logic [15:0] SPEED_NO_TIME = 16'd25344;  // 99.0 in q8.8
  localparam logic [15:0] SPEED_MAX     = 16'hFFFF;
  localparam logic [9:0]  FACTOR_BASE   = 10'd100;

  // base ratios in q0.24, rounded to nearest
  localparam longint unsigned RATIO_KMH_Q24 =
    (64'd16777216 * 64'd129 + 64'd235) / 64'd470;
  localparam longint unsigned RATIO_MPH_Q24 =
    (64'd16777216 * 64'd645000 + 64'd1890974) / 64'd3781949;

  // arithmetic widths: pulses (PTR_W bits, 8 at the default depth) * factor (8b) is the serial multiplier
  localparam int NUM_W     = 64;
  localparam int MULT_W    = 20;
  localparam int DEN_W     = 39;   // 100 * ticks
  localparam int QUOT_W    = 16;
  localparam int DIV_STEPS = NUM_W - 16;  // dividend is num >> 16
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic              start;
    logic [MULT_W-1:0] mult;
    logic [NUM_W-1:0]  k;
    logic [31:0]       ticks;
  } calc_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] speed;
  } calc_resp_t;

endpackage

`default_nettype wire

// ===== design/wheel_speed_from_pulse_periods_unit.sv =====
// top level of the wheel speed unit: period fifo, drain sequencer, outputs
// depends on wsp_pkg and wsp_speed_calc
`default_nettype none

// Capture requests store the period since the previous edge in a fifo of
// FIFO_DEPTH-1 usable entries. A tick request drains the fifo one entry per
// cycle through the memory read port, then runs the speed calculation on
// one shared 64-bit adder (20 multiply steps, 48 divide steps). The unit
// takes one request at a time; a finished result waits in the output
// register while the next request is already accepted. There is no
// clearing pass after reset.
module wheel_speed_from_pulse_periods_unit #(
  parameter int FIFO_DEPTH       = 256,
  parameter int MAX_PERIOD_TICKS = 50000,
  parameter int TIMER_RATE_HZ    = 10000
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wsp_pkg::wsp_in_t                    in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output wsp_pkg::wsp_out_t                   out_data,
  input  wire                                 cfg_we,
  input  wsp_pkg::cfg_index_t                 cfg_index,
  input  wire [wsp_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wsp_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [15:0] MAX_P = 16'(MAX_PERIOD_TICKS);
  localparam logic [NUM_W-1:0] K_KMH = NUM_W'(64'(TIMER_RATE_HZ) * RATIO_KMH_Q24);
  localparam logic [NUM_W-1:0] K_MPH = NUM_W'(64'(TIMER_RATE_HZ) * RATIO_MPH_Q24);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  wsp_state_t state;
  wsp_state_t state_next;

  // configuration
  logic       miles_mode;
  logic [7:0] ratio_adjust;

  // state
  logic [31:0]      last_edge;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [31:0]      acc_ticks;
  logic [3:0]       idle_cnt;
  logic [15:0]      speed;
  logic [31:0]      pulse_total;

  // per-request working registers
  logic             pend;
  logic [PTR_W-1:0] cnt;
  logic             stop;
  logic             accepted;
  logic [7:0]       counted;

  // fifo memory
  logic [15:0] fifo_mem [FIFO_DEPTH];
  logic [15:0] rd_data;
  logic        fifo_we;
  logic [15:0] wr_period;
  logic [31:0] elapsed;
  logic        fifo_full;

  logic        in_fire;
  logic        load_out;
  logic        calc_go;
  logic        pulses_ok;
  logic [9:0]  factor;
  logic        factor_pos;
  logic [15:0] drain_p;
  logic [32:0] acc_sum;

  calc_req_t  calc_req;
  calc_resp_t calc_resp;

  assign in_fire    = in_valid & in_ready;
  assign elapsed    = in_data.capture_time - last_edge;
  assign fifo_full  = (ptr_inc(wr_ptr) == rd_ptr);
  assign fifo_we    = in_fire && (in_data.operation == OP_CAPTURE) && !fifo_full;
  assign wr_period  = (elapsed <= 32'(MAX_P)) ? elapsed[15:0] : 16'd0;
  assign pulses_ok  = !stop && (cnt != '0);
  assign factor     = {{2{ratio_adjust[7]}}, ratio_adjust} + FACTOR_BASE;
  assign factor_pos = !factor[9] && (factor != '0);

  // a stored zero marks a stop and counts as the longest period
  assign drain_p = (rd_data == 16'd0) ? MAX_P : rd_data;
  assign acc_sum = {1'b0, acc_ticks} + 33'(drain_p);

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[wr_ptr] <= wr_period;
    end
    rd_data <= fifo_mem[rd_ptr];
  end

  assign calc_req.start = calc_go;
  assign calc_req.mult  = MULT_W'(cnt) * MULT_W'(factor[7:0]);
  assign calc_req.k     = miles_mode ? K_MPH : K_KMH;
  assign calc_req.ticks = acc_ticks;

  wsp_speed_calc u_calc (
    .clk  (clk),
    .rst  (rst),
    .req  (calc_req),
    .resp (calc_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    calc_go    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_data.operation == OP_TICK) ? S_DRAIN : S_DONE;
        end
      end
      S_DRAIN: begin
        if (!pend && rd_ptr == wr_ptr) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (pulses_ok && acc_ticks != '0 && factor_pos) begin
          calc_go    = 1'b1;
          state_next = S_CALC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CALC: begin
        if (calc_resp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      miles_mode   <= 1'b0;
      ratio_adjust <= '0;
      last_edge    <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      acc_ticks    <= '0;
      idle_cnt     <= '0;
      speed        <= '0;
      pulse_total  <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MILES_MODE:   miles_mode   <= cfg_data[0];
          CFG_RATIO_ADJUST: ratio_adjust <= cfg_data;
          default:          miles_mode   <= miles_mode;
        endcase
      end

      if (in_fire) begin
        pend <= 1'b0;
        if (in_data.operation == OP_CAPTURE) begin
          last_edge <= in_data.capture_time;
          if (!fifo_full) begin
            wr_ptr <= ptr_inc(wr_ptr);
          end
        end
      end

      if (state == S_DRAIN) begin
        pend <= (rd_ptr != wr_ptr);
        if (rd_ptr != wr_ptr) begin
          rd_ptr <= ptr_inc(rd_ptr);
        end
        if (pend) begin
          // saturating per step equals saturating the total
          acc_ticks <= acc_sum[32] ? '1 : acc_sum[31:0];
        end
      end

      if (state == S_DECIDE) begin
        if (pulses_ok) begin
          pulse_total <= pulse_total + 32'(cnt);
          acc_ticks   <= '0;
          idle_cnt    <= '0;
          if (acc_ticks == '0) begin
            speed <= SPEED_NO_TIME;
          end else if (!factor_pos) begin
            speed <= '0;
          end
        end else if (idle_cnt < IDLE_LIMIT) begin
          idle_cnt <= idle_cnt + 1'b1;
        end else begin
          speed <= '0;
        end
      end

      if (state == S_CALC && calc_resp.done) begin
        speed <= calc_resp.speed;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-request payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cnt      <= '0;
      stop     <= 1'b0;
      counted  <= '0;
      accepted <= (in_data.operation == OP_CAPTURE) && !fifo_full;
    end
    if (state == S_DRAIN && pend) begin
      cnt <= cnt + 1'b1;
      if (rd_data == 16'd0) begin
        stop <= 1'b1;
      end
    end
    if (state == S_DECIDE && pulses_ok) begin
      counted <= 8'(cnt);
    end
    if (load_out) begin
      out_data.edge_accepted  <= accepted;
      out_data.speed_value    <= speed;
      out_data.pulses_counted <= counted;
      out_data.partial_pulses <= pulse_total;
      out_data.pending_ticks  <= acc_ticks;
    end
  end

  // calculator only answers while the sequencer waits for it
  a_calc_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    calc_resp.done |-> (state == S_CALC))
    else $error("speed calculator finished outside its wait state");

  // a full fifo never advances the write pointer
  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.operation == OP_CAPTURE && fifo_full) |=>
      (wr_ptr == $past(wr_ptr)))
    else $error("write pointer moved on a full fifo");

  // the drain leaves the fifo empty
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (rd_ptr == wr_ptr && !pend))
    else $error("decision taken before the fifo was drained");

  // a tick that counted pulses consumes the pending ticks
  a_ticks_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && pulses_ok) |=> (acc_ticks == '0))
    else $error("pending ticks kept after a speed update");

endmodule

`default_nettype wire

// ===== design/wsp_speed_calc.sv =====
// speed calculator: floor(mult * k / (100 * ticks * 2^16)), saturated to 16 bits
// one shared 64-bit add/subtract unit does the shift-add multiply and the
// restoring divide; depends on wsp_pkg
`default_nettype none

module wsp_speed_calc (
  input  wire                 clk,
  input  wire                 rst,
  input  wsp_pkg::calc_req_t  req,
  output wsp_pkg::calc_resp_t resp
);
  import wsp_pkg::*;

  calc_state_t       state;
  calc_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic [MULT_W-1:0] mult;
  logic [NUM_W-1:0]  kval;
  logic [NUM_W-1:0]  acc;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [QUOT_W-1:0] quot;
  logic              ovf;

  // shared adder
  logic [NUM_W-1:0] op_a;
  logic [NUM_W-1:0] op_b;
  logic             op_sub;
  logic [NUM_W:0]   sum;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, acc[NUM_W-1]};

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    if (state == C_DIV) begin
      op_a   = NUM_W'(rem_sh);
      op_b   = NUM_W'(den);
      op_sub = 1'b1;
    end else begin
      op_a = {acc[NUM_W-2:0], 1'b0};
      op_b = mult[MULT_W-1] ? kval : '0;
    end
    sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (NUM_W+1)'(op_sub);
    ge  = sum[NUM_W];  // no borrow: remainder >= divisor
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    resp.done  = 1'b0;
    resp.speed = ovf ? SPEED_MAX : quot;
    unique case (state)
      C_IDLE: begin
        if (req.start) begin
          state_next = C_MUL;
        end
      end
      C_MUL: begin
        if (step == '0) begin
          state_next = C_DIV;
        end
      end
      C_DIV: begin
        if (step == '0) begin
          state_next = C_DONE;
        end
      end
      C_DONE: begin
        resp.done  = 1'b1;
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      C_IDLE: begin
        mult <= req.mult;
        kval <= req.k;
        acc  <= '0;
        // 100 * ticks as shifted adds
        den  <= (DEN_W'(req.ticks) << 6) + (DEN_W'(req.ticks) << 5) +
                (DEN_W'(req.ticks) << 2);
        step <= STEP_W'(MULT_W - 1);
      end
      C_MUL: begin
        acc  <= sum[NUM_W-1:0];
        mult <= {mult[MULT_W-2:0], 1'b0};
        step <= (step == '0) ? STEP_W'(DIV_STEPS - 1) : step - 1'b1;
        rem  <= '0;
        quot <= '0;
        ovf  <= 1'b0;
      end
      C_DIV: begin
        rem  <= ge ? sum[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quot <= {quot[QUOT_W-2:0], ge};
        ovf  <= ovf | quot[QUOT_W-1];
        acc  <= {acc[NUM_W-2:0], 1'b0};
        step <= step - 1'b1;
      end
      C_DONE: begin
        step <= '0;
      end
      default: step <= '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/wsp_speed_checker.sv =====
// checker for the wheel speed unit: watches the request, result and config ports,
// predicts each result from its own copy of the unit state and compares in order
// depends on wsp_pkg
`default_nettype none

module wsp_speed_checker (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire                           in_ready,
  input  wsp_pkg::wsp_in_t              in_data,
  input  wire                           out_valid,
  input  wire                           out_ready,
  input  wsp_pkg::wsp_out_t             out_data,
  input  wire                           cfg_we,
  input  wsp_pkg::cfg_index_t           cfg_index,
  input  wire [wsp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  localparam int unsigned     PERIOD_CAP    = 50000;
  localparam longint unsigned RATE_HZ       = 10000;
  localparam logic [3:0]      IDLE_MAX      = 4'd10;
  localparam logic [15:0]     NO_TIME_SPEED = 16'd25344;
  // wheel ratios in q0.24, rounded to nearest
  localparam longint unsigned KMH_Q24 = (64'd33554432 * 64'd129 + 64'd470) / 64'd940;
  localparam longint unsigned MPH_Q24 =
    (64'd33554432 * 64'd645000 + 64'd3781949) / 64'd7563898;

  logic              mph_sel;
  logic signed [7:0] adjust_pct;
  logic [31:0]       edge_stamp;
  logic [15:0]       period_mem [0:255];
  logic [7:0]        wr_slot;
  logic [7:0]        rd_slot;
  logic [31:0]       tick_acc;
  logic [3:0]        idle_ticks;
  logic [15:0]       speed_q88;
  logic [31:0]       pulse_sum;
  wsp_out_t          expected_q [$];
  int                fail_tally = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] speed_for(input longint unsigned pulses,
                                            input longint unsigned ticks);
    longint          factor;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    if (ticks == 0) return NO_TIME_SPEED;
    factor = 100 + longint'(adjust_pct);
    if (factor <= 0) return 16'd0;
    num = pulses * RATE_HZ * 64'(factor);
    num = num * (mph_sel ? MPH_Q24 : KMH_Q24);
    den = 64'd100 * ticks * 64'd65536;
    q = num / den;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic wsp_out_t apply_request(input wsp_in_t req);
    wsp_out_t        rsp;
    logic [31:0]     elapsed;
    logic [7:0]      nxt;
    longint unsigned sum;
    longint unsigned acc;
    int unsigned     count;
    logic            stop;
    logic [15:0]     per;
    rsp = '0;
    if (req.operation == OP_CAPTURE) begin
      elapsed = req.capture_time - edge_stamp;
      nxt = wr_slot + 8'd1;
      edge_stamp = req.capture_time;
      // one slot stays free, so a full fifo drops the period
      if (nxt != rd_slot) begin
        period_mem[wr_slot] = (elapsed <= PERIOD_CAP) ? elapsed[15:0] : 16'd0;
        wr_slot = nxt;
        rsp.edge_accepted = 1'b1;
      end
    end else begin
      sum = 0;
      count = 0;
      stop = 1'b0;
      while (rd_slot != wr_slot) begin
        per = period_mem[rd_slot];
        if (per == 16'd0) begin
          stop = 1'b1;
          sum += PERIOD_CAP;
        end else begin
          sum += per;
        end
        count++;
        rd_slot = rd_slot + 8'd1;
      end
      acc = tick_acc + sum;
      tick_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
      if (!stop && count != 0) begin
        speed_q88 = speed_for(count, tick_acc);
        pulse_sum = pulse_sum + count;
        tick_acc = '0;
        idle_ticks = '0;
        rsp.pulses_counted = count[7:0];
      end else if (idle_ticks < IDLE_MAX) begin
        idle_ticks++;
      end else begin
        speed_q88 = '0;
      end
    end
    rsp.speed_value    = speed_q88;
    rsp.partial_pulses = pulse_sum;
    rsp.pending_ticks  = tick_acc;
    return rsp;
  endfunction

  always @(posedge clk) begin
    wsp_out_t want;
    if (rst) begin
      mph_sel    = 1'b0;
      adjust_pct = '0;
      edge_stamp = '0;
      wr_slot    = '0;
      rd_slot    = '0;
      tick_acc   = '0;
      idle_ticks = '0;
      speed_q88  = '0;
      pulse_sum  = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MILES_MODE) mph_sel = cfg_data[0];
        else if (cfg_index == CFG_RATIO_ADJUST) adjust_pct = cfg_data;
      end
      if (in_valid && in_ready) expected_q.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: result with no request waiting: acc=%0b speed=%h pulses=%0d",
                     $realtime, out_data.edge_accepted, out_data.speed_value,
                     out_data.pulses_counted);
        end else begin
          want = expected_q.pop_front();
          if (out_data !== want) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("%0t: mismatch, expected acc=%0b speed=%h pulses=%0d partial=%h pend=%h",
                       $realtime, want.edge_accepted, want.speed_value, want.pulses_counted,
                       want.partial_pulses, want.pending_ticks);
              $display("%0t:           actual acc=%0b speed=%h pulses=%0d partial=%h pend=%h",
                       $realtime, out_data.edge_accepted, out_data.speed_value,
                       out_data.pulses_counted, out_data.partial_pulses,
                       out_data.pending_ticks);
            end
          end
        end
      end
    end
    outstanding <= expected_q.size();
    mismatches  <= fail_tally;
  end

endmodule

`default_nettype wire

// ===== tb/sv/wheel_speed_from_pulse_periods_unit_tb.sv =====
// testbench top for wheel_speed_from_pulse_periods_unit: clock, reset, stimulus
// and verdict; depends on wsp_pkg, the unit and wsp_speed_checker
`default_nettype none

module wheel_speed_from_pulse_periods_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 400;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  wsp_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  wsp_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  cfg_index_t            cfg_index = CFG_MILES_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  logic [31:0] last_stamp  = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wheel_speed_from_pulse_periods_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wsp_speed_checker speed_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_req(input logic op, input logic [31:0] stamp);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, stamp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_capture(input logic [31:0] elapsed);
    last_stamp = last_stamp + elapsed;
    send_req(OP_CAPTURE, last_stamp);
  endtask

  // the time field is don't-care on a tick, so it carries noise
  task automatic send_tick();
    send_req(OP_TICK, $urandom);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_config(input logic miles, input int adjust);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MILES_MODE;
    cfg_data  <= {7'd0, miles};
    @(posedge clk);
    cfg_index <= CFG_RATIO_ADJUST;
    cfg_data  <= 8'(adjust);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(0, 19))
      0:             return 32'd0;
      1:             return $urandom_range(50001, 32'hFFFF_FFFF);
      2:             return 32'd50000;
      3, 4, 5:       return $urandom_range(1, 20);
      6:             return $urandom;
      7, 8, 9, 10:   return $urandom_range(1, 2000);
      default:       return $urandom_range(1, 50000);
    endcase
  endfunction

  // bursts of edges, each closed by a compute tick
  task automatic run_phase(input int n_items, input bit full_first);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 59))
        0:             burst = $urandom_range(250, 270);
        1, 2, 3, 4, 5: burst = 0;
        default:       burst = $urandom_range(1, 12);
      endcase
      if (full_first && sent == 0) burst = 262;
      repeat (burst) send_capture(pick_elapsed());
      send_tick();
      sent += burst + 1;
    end
  endtask

  task automatic do_phase(input int gap, input int stall, input logic miles,
                          input int adjust, input bit full_first, input int n_items);
    set_config(miles, adjust);
    gap_pct   = gap;
    stall_pct = stall;
    run_phase(n_items, full_first);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tick, zero and too long periods, timestamp wrap,
    // the longest valid period, a saturated speed, then idle ticks to zero
    send_tick();
    send_capture(32'd0);
    send_capture(32'hFFFF_FFFF - last_stamp);
    send_capture(32'd16);
    send_capture(32'd50000);
    send_capture(32'd50001);
    send_tick();
    send_capture(32'd1);
    send_capture(32'd20);
    send_tick();
    send_capture(32'd1);
    send_capture(32'd1);
    send_tick();
    repeat (12) send_tick();

    // runs of stop periods that pile up pending ticks
    set_config(1'b0, 0);
    repeat (2) begin
      repeat (250) send_capture($urandom_range(50001, 32'hFFFF_FFFF));
      send_tick();
    end
    repeat (3) send_capture($urandom_range(1, 100));
    send_tick();

    do_phase(0,  0,  1'b1, 100,  1'b1, 140);
    do_phase(88, 0,  1'b0, -100, 1'b0, 140);
    do_phase(0,  88, 1'b1, -100, 1'b1, 140);
    do_phase(31, 31, 1'b0, 100,  1'b0, 140);
    do_phase(0,  0,  1'b0, int'($urandom_range(0, 200)) - 100, 1'b0, 140);
    do_phase(88, 0,  1'b1, int'($urandom_range(0, 200)) - 100, 1'b0, 140);
    do_phase(0,  88, 1'b0, 0,    1'b0, 140);
    do_phase(31, 31, 1'b1, int'($urandom_range(0, 200)) - 100, 1'b1, 140);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/wsp_pkg.sv
design/wsp_speed_calc.sv
design/wheel_speed_from_pulse_periods_unit.sv
tb/sv/wsp_speed_checker.sv
tb/sv/wheel_speed_from_pulse_periods_unit_tb.sv
